// ----- rtl/dsc_pkg.sv -----
// ----------------------------------------------------------------------------
// dsc_pkg
// types and constants shared by the dmx slot capture block
// ----------------------------------------------------------------------------
package dsc_pkg;

    // request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // slot numbering
    localparam logic [8:0] SLOT_START_CODE   = 9'd1;
    localparam logic [8:0] SLOT_FIRST_DATA   = 9'd2;
    localparam logic [8:0] SLOT_LAST_COUNTED = 9'd255;
    localparam logic [8:0] BASE_SLOT_RESET   = 9'd2;

    // last pwm count before the wrap
    localparam logic [7:0] PWM_LAST = 8'd255;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic       framing_error;
    } t_dsc_in;

    typedef struct packed {
        logic led_red;
        logic led_green;
        logic led_blue;
    } t_dsc_out;

endpackage

// ----- rtl/dmx_slot_capture_rgb_pwm_top.sv -----
// ----------------------------------------------------------------------------
// dmx_slot_capture_rgb_pwm_top
// dmx512 slot capture feeding a three channel soft pwm for an rgb led
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_*): one beat is either a received uart byte with its
//   framing error flag (a framing error marks a dmx break) or a pwm tick.
//   output channel (o_out_*): exactly one beat per input beat, carrying the
//   red, green and blue led levels after that item, in input order.
//   config channel (i_cfg_*): writes base_slot, the slot number of the first
//   captured level (blue); green and red follow. write only while idle.
// timing
//   an accepted beat lands in the input register, is processed from there into
//   the result register, and is offered from the result register until taken.
//   one beat per cycle sustained while the receiver takes results, set by the
//   single pass from input register to result register.
// reset and stall
//   reset clears slot state to slot 2, levels to zero, pwm count to zero and
//   all leds off; base_slot returns to 2. when the receiver stalls, the held
//   result and one waiting input beat fill both registers, then ready drops.
// ----------------------------------------------------------------------------
module dmx_slot_capture_rgb_pwm_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dsc_pkg::t_dsc_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dsc_pkg::t_dsc_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [8:0]        i_cfg_data
);
    import dsc_pkg::*;

    // configuration
    logic [8:0] r_base_slot;

    // input register
    logic       r_in_valid;
    t_dsc_in    r_in_data;

    // block state
    logic [8:0] r_slot, n_slot;
    logic       r_halted, n_halted;
    logic [7:0] r_lvl_blue, n_lvl_blue;
    logic [7:0] r_lvl_green, n_lvl_green;
    logic [7:0] r_lvl_red, n_lvl_red;
    logic [7:0] r_pwm, n_pwm;
    t_dsc_out   r_led, n_led;

    // result register
    logic       r_out_valid;
    t_dsc_out   r_out_data;

    // window compare, done one bit wider so base_slot + 2 never wraps
    logic [9:0] win_lo;
    logic [9:0] win_hi;
    logic [9:0] slot_ext;
    logic       in_window;
    logic [1:0] slot_ofs;
    logic       advance;

    // the input register moves on whenever the result register is free
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign slot_ext  = {1'b0, r_slot};
    assign win_lo    = {1'b0, r_base_slot};
    assign win_hi    = {1'b0, r_base_slot} + 10'd2;
    assign in_window = (slot_ext >= win_lo) && (slot_ext <= win_hi);
    // offset inside the window is 0..2, so the low two bits are enough
    assign slot_ofs  = r_slot[1:0] - r_base_slot[1:0];

    always_comb begin
        n_slot      = r_slot;
        n_halted    = r_halted;
        n_lvl_blue  = r_lvl_blue;
        n_lvl_green = r_lvl_green;
        n_lvl_red   = r_lvl_red;
        n_pwm       = r_pwm;
        n_led       = r_led;
        if (r_in_data.req_type == REQ_BYTE) begin
            priority if (r_in_data.framing_error) begin
                // break: back to the start code position
                n_slot   = SLOT_START_CODE;
                n_halted = 1'b0;
            end else if (r_halted) begin
                n_halted = 1'b1;
            end else if (r_slot == SLOT_START_CODE) begin
                // only the null start code carries dimmer data
                if (r_in_data.rx_byte == 8'd0) begin
                    n_slot = SLOT_FIRST_DATA;
                end else begin
                    n_halted = 1'b1;
                end
            end else if (in_window) begin
                unique case (slot_ofs)
                    2'd0:    n_lvl_blue  = r_in_data.rx_byte;
                    2'd1:    n_lvl_green = r_in_data.rx_byte;
                    2'd2:    n_lvl_red   = r_in_data.rx_byte;
                    default: n_lvl_red   = r_lvl_red;
                endcase
                n_slot = r_slot + 9'd1;
            end else if (r_slot != 9'd0 && r_slot <= SLOT_LAST_COUNTED) begin
                n_slot = r_slot + 9'd1;
            end else begin
                // ran off the end of the frame without a match
                n_halted = 1'b1;
            end
        end else begin
            if (r_pwm == PWM_LAST) begin
                // period start: every nonzero level lights its led
                n_pwm           = 8'd0;
                n_led.led_blue  = (r_lvl_blue != 8'd0);
                n_led.led_green = (r_lvl_green != 8'd0);
                n_led.led_red   = (r_lvl_red != 8'd0);
            end else begin
                n_pwm = r_pwm + 8'd1;
                if (r_lvl_blue < n_pwm) begin
                    n_led.led_blue = 1'b0;
                end
                if (r_lvl_green < n_pwm) begin
                    n_led.led_green = 1'b0;
                end
                if (r_lvl_red < n_pwm) begin
                    n_led.led_red = 1'b0;
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_slot <= BASE_SLOT_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_slot      <= SLOT_FIRST_DATA;
            r_halted    <= 1'b0;
            r_lvl_blue  <= 8'd0;
            r_lvl_green <= 8'd0;
            r_lvl_red   <= 8'd0;
            r_pwm       <= 8'd0;
            r_led       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_base_slot <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_slot      <= n_slot;
                r_halted    <= n_halted;
                r_lvl_blue  <= n_lvl_blue;
                r_lvl_green <= n_lvl_green;
                r_lvl_red   <= n_lvl_red;
                r_pwm       <= n_pwm;
                r_led       <= n_led;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_led;
        end
    end

    // a break always lands on the start code slot with reception enabled
    a_break_resets_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_data.req_type == REQ_BYTE && r_in_data.framing_error
        |=> r_slot == SLOT_START_CODE && !r_halted)
        else $error("break did not return to start code slot");

    // the pwm counter wraps to zero after its last count
    a_pwm_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_data.req_type == REQ_TICK && r_pwm == PWM_LAST
        |=> r_pwm == 8'd0)
        else $error("pwm counter did not wrap");

    // the offered result always matches the current led state
    a_out_matches_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data == r_led)
        else $error("result differs from led state");

    // with both registers full and the receiver stalled, no new beat is taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready && r_in_valid |-> !o_in_ready)
        else $error("input accepted while pipeline full");

    // a byte never touches the pwm counter
    a_byte_keeps_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_data.req_type == REQ_BYTE |=> $stable(r_pwm))
        else $error("byte changed pwm counter");

endmodule
